[rtl/kbi_pkg.sv]
// shared types and constants for the keyed breakpoint interpolator
`default_nettype none
package kbi_pkg;
	localparam int NOTE_SLOTS = 128;
	localparam int NOTE_W = 7;

	typedef enum logic [2:0] {
		CMD_LOOKUP = 3'd0,
		CMD_MARK   = 3'd1,
		CMD_WRITE  = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_CLEAR  = 3'd4,
		CMD_DEFLT  = 3'd5
	} cmd_t;

	typedef struct packed {
		logic       scan_start;
		logic       scan_step;
		logic       div_start;
		logic       div_step;
		logic       rd_lo;
		logic       rd_hi;
		logic       mul_go;
		logic       out_load;
	} kbi_ctl_t;

	typedef struct packed {
		logic       scan_done;
		logic       div_done;
	} kbi_sts_t;
endpackage
`default_nettype wire

[rtl/kbi_in_if.sv]
// input channel: command transaction
`default_nettype none
interface kbi_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic signed [15:0] note;
	logic [7:0]         oscillator;
	logic [3:0]         param_index;
	logic signed [31:0] write_value;
	modport source (output valid, command, note, oscillator, param_index, write_value,
		input ready);
	modport sink (input valid, command, note, oscillator, param_index, write_value,
		output ready);
endinterface
`default_nettype wire

[rtl/kbi_out_if.sv]
// output channel: result transaction
`default_nettype none
interface kbi_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               removed;
	modport source (output valid, result_value, removed, input ready);
	modport sink (input valid, result_value, removed, output ready);
endinterface
`default_nettype wire

[rtl/kbi_ctrl.sv]
// controller state machine sequencing lookups and commands
`default_nettype none
module kbi_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  wire logic            is_interp,
	input  wire logic            out_free,
	input  wire kbi_pkg::kbi_sts_t sts,
	output kbi_pkg::kbi_ctl_t    ctl,
	output logic                 busy
);
	import kbi_pkg::*;
	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DIV, S_RDLO, S_RDHI, S_MUL, S_MUL2, S_OUT
	} state_t;
	state_t state_q;

	always_comb begin
		ctl = '0;
		ctl.scan_start = in_fire;
		unique case (state_q)
			S_IDLE: ;
			S_SCAN: ctl.scan_step = 1'b1;
			S_DIV:  ctl.div_step = 1'b1;
			S_RDLO: ctl.rd_lo = 1'b1;
			S_RDHI: ctl.rd_hi = 1'b1;
			S_MUL:  ctl.mul_go = 1'b1;
			S_MUL2: ;
			S_OUT:  ctl.out_load = out_free;
			default: ;
		endcase
		ctl.div_start = (state_q == S_SCAN) && sts.scan_done;
	end
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_done) state_q <= is_interp ? S_DIV : S_RDLO;
				S_DIV:  if (sts.div_done) state_q <= S_RDLO;
				S_RDLO: state_q <= S_RDHI;
				S_RDHI: state_q <= S_MUL;
				S_MUL:  state_q <= S_MUL2;
				S_MUL2: state_q <= S_OUT;
				S_OUT:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/kbi_dp.sv]
// datapath: key map, value memories, neighbor scan, divider, blend
`default_nettype none
module kbi_dp #(
	parameter int NOTE_MIN = 0,
	parameter int NOTE_MAX = 127,
	parameter int OSCILLATOR_COUNT = 8,
	parameter int PARAM_COUNT = 11
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_fire,
	input  wire logic [2:0]         command,
	input  wire logic signed [15:0] note,
	input  wire logic [7:0]         oscillator,
	input  wire logic [3:0]         param_index,
	input  wire logic signed [31:0] write_value,
	input  wire kbi_pkg::kbi_ctl_t  ctl,
	output kbi_pkg::kbi_sts_t       sts,
	output logic                    is_interp,
	output logic signed [31:0]      res_value,
	output logic                    res_removed
);
	import kbi_pkg::*;
	localparam int SET_SIZE = OSCILLATOR_COUNT * PARAM_COUNT;
	localparam int SLOT_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
	localparam int KEY_DEPTH = NOTE_SLOTS * SET_SIZE;
	localparam int KEY_W = $clog2(KEY_DEPTH);
	localparam int OSC_W = (OSCILLATOR_COUNT > 1) ? $clog2(OSCILLATOR_COUNT) : 1;

	logic [NOTE_SLOTS-1:0] present_q;
	logic signed [31:0] key_mem [KEY_DEPTH];
	logic signed [31:0] def_mem [SET_SIZE];

	// note rounding and clamping
	logic [15:0] mag;
	logic [8:0]  rnd;
	logic signed [9:0] nsg;
	logic [NOTE_W-1:0] n_c;
	always_comb begin
		mag = note[15] ? (16'd0 - note) : note;
		rnd = 9'((17'(mag) + 17'd128) >> 8);
		nsg = note[15] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
		if (nsg < 10'(NOTE_MIN)) nsg = 10'(NOTE_MIN);
		if (nsg > 10'(NOTE_MAX)) nsg = 10'(NOTE_MAX);
		n_c = NOTE_W'(nsg);
	end

	logic [OSC_W-1:0] osc_c;
	logic [SLOT_W-1:0] slot_c;
	logic par_ok_c;
	always_comb begin
		osc_c = (oscillator > 8'(OSCILLATOR_COUNT - 1)) ? OSC_W'(OSCILLATOR_COUNT - 1)
			: OSC_W'(oscillator);
		slot_c = SLOT_W'(osc_c * PARAM_COUNT + param_index);
		par_ok_c = {1'b0, param_index} < 5'(PARAM_COUNT);
	end

	// latched transaction
	cmd_t              cmd_q;
	logic [NOTE_W-1:0] n_q;
	logic [SLOT_W-1:0] slot_q;
	logic              par_ok_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= cmd_t'(command);
			n_q <= n_c;
			slot_q <= slot_c;
			par_ok_q <= par_ok_c;
			if (par_ok_c && command == CMD_WRITE)
				key_mem[KEY_W'(n_c * SET_SIZE + slot_c)] <= write_value;
			if (par_ok_c && command == CMD_DEFLT)
				def_mem[slot_c] <= write_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			res_removed <= 1'b0;
		end else if (in_fire) begin
			res_removed <= (command == CMD_REMOVE) && present_q[n_c];
			unique case (command)
				CMD_MARK: present_q[n_c] <= 1'b1;
				CMD_REMOVE: present_q[n_c] <= 1'b0;
				CMD_CLEAR: present_q <= '0;
				default: ;
			endcase
		end
	end

	// neighbor scan, one note per cycle
	logic [NOTE_W:0] idx_q;
	logic [NOTE_W-1:0] first_q, last_q, lower_q, upper_q;
	logic any_q, up_q;
	logic [NOTE_W-1:0] idx;
	logic [4:0] dcnt_q;
	assign idx = idx_q[NOTE_W-1:0];
	assign sts = {idx_q[NOTE_W], dcnt_q == 5'd16};

	always_ff @(posedge clk) begin
		if (ctl.scan_start) begin
			idx_q <= '0;
			any_q <= 1'b0;
			up_q <= 1'b0;
		end else if (ctl.scan_step && !idx_q[NOTE_W]) begin
			idx_q <= idx_q + 1'b1;
			if (present_q[idx]) begin
				if (!any_q) first_q <= idx;
				any_q <= 1'b1;
				last_q <= idx;
				if (idx < n_q) lower_q <= idx;
				if (idx > n_q && !up_q) begin
					upper_q <= idx;
					up_q <= 1'b1;
				end
			end
		end
	end

	// selection of read addresses
	logic use_def, exact;
	logic [NOTE_W-1:0] lo_note, hi_note;
	always_comb begin
		use_def = !any_q;
		is_interp = 1'b0;
		exact = 1'b1;
		lo_note = n_q;
		if (n_q <= first_q) lo_note = first_q;
		else if (n_q >= last_q) lo_note = last_q;
		else if (!present_q[n_q]) begin
			is_interp = any_q;
			exact = 1'b0;
			lo_note = lower_q;
		end
		hi_note = exact ? lo_note : upper_q;
	end

	// restoring divider: t = ((n-lo) << 16) / (hi-lo)
	logic [NOTE_W-1:0] rem_q;
	logic [15:0] quo_q;
	logic [NOTE_W-1:0] dvs;
	logic [NOTE_W:0] trial;
	assign dvs = upper_q - lower_q;
	assign trial = {rem_q, 1'b0} - {1'b0, dvs};
	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			dcnt_q <= '0;
			rem_q <= n_q - lower_q;
			quo_q <= '0;
		end else if (ctl.div_step && dcnt_q != 5'd16) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (!trial[NOTE_W]) begin
				rem_q <= trial[NOTE_W-1:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_q << 1;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	// memory reads and blend
	logic signed [31:0] rd_q, lo_q;
	logic signed [32:0] diff_s1;
	logic signed [49:0] prod_s2;
	logic signed [33:0] sum;
	always_ff @(posedge clk) begin
		if (ctl.rd_lo)
			rd_q <= use_def ? def_mem[slot_q] : key_mem[KEY_W'(lo_note * SET_SIZE + slot_q)];
		if (ctl.rd_hi) begin
			lo_q <= rd_q;
			rd_q <= key_mem[KEY_W'(hi_note * SET_SIZE + slot_q)];
		end
		if (ctl.mul_go)
			diff_s1 <= is_interp ? (33'(rd_q) - 33'(lo_q)) : 33'sd0;
		prod_s2 <= diff_s1 * $signed({1'b0, quo_q});
	end
	always_comb begin
		sum = 34'(lo_q) + 34'((prod_s2 + (prod_s2[49] ? 50'sd65535 : 50'sd0)) >>> 16);
	end
	always_ff @(posedge clk) begin
		if (ctl.out_load)
			res_value <= (cmd_q == CMD_LOOKUP && par_ok_q) ? 32'(sum) : 32'sd0;
	end
endmodule
`default_nettype wire

[rtl/keyed_breakpoint_interpolator.sv]
// Keyed breakpoint interpolator top level. One transaction at a time: every command scans
// the presence map one note per cycle, a command whose note falls between two keys then
// runs the 16-step bit-serial divider for the blend factor, and the two memory reads, the
// multiply and the result register follow. The input is held off until the result has
// been taken, so no new transaction is accepted while one is in flight or while its
// result waits on the result side.
`default_nettype none
module keyed_breakpoint_interpolator #(
	parameter int NOTE_MIN = 0,
	parameter int NOTE_MAX = 127,
	parameter int OSCILLATOR_COUNT = 8,
	parameter int PARAM_COUNT = 11
) (
	input wire logic clk,
	input wire logic arst_n,
	kbi_in_if.sink   in_ch,
	kbi_out_if.source out_ch
);
	import kbi_pkg::*;
	kbi_ctl_t ctl;
	kbi_sts_t sts;
	logic busy, is_interp, in_fire, out_free, valid_q, removed;
	logic signed [31:0] value;

	assign in_ch.ready = !busy && !valid_q;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_free = !valid_q;

	kbi_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .is_interp, .out_free, .sts, .ctl, .busy
	);

	kbi_dp #(
		.NOTE_MIN(NOTE_MIN), .NOTE_MAX(NOTE_MAX),
		.OSCILLATOR_COUNT(OSCILLATOR_COUNT), .PARAM_COUNT(PARAM_COUNT)
	) u_dp (
		.clk, .arst_n, .in_fire,
		.command(in_ch.command), .note(in_ch.note), .oscillator(in_ch.oscillator),
		.param_index(in_ch.param_index), .write_value(in_ch.write_value),
		.ctl, .sts, .is_interp, .res_value(value), .res_removed(removed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end
	assign out_ch.valid = valid_q;
	assign out_ch.result_value = value;
	assign out_ch.removed = removed;
endmodule
`default_nettype wire

[rtl/kbi_checker.sv]
// port-level checks for the keyed breakpoint interpolator
`default_nettype none
module kbi_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_removed,
	input wire logic [31:0] out_value
);
	a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
	a_no_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(out_value) && $stable(out_removed))
		else $error("result changed while stalled");
endmodule

bind keyed_breakpoint_interpolator kbi_checker u_kbi_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_removed(out_ch.removed), .out_value(out_ch.result_value)
);
`default_nettype wire
